/* hdl/hsp_pkg.sv */
// Shared constants and status types for the host-synced phasor.
// No dependencies.
package hsp_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int BEAT_LIMIT     = 100000;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MARK_ROUND     = 5000;
    localparam int MARK_DEN       = 10000;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* hdl/host_synced_phasor.sv */
// Host-synced phasor: a 0..1 ramp locked to a host beat position.
// A tick word passes through the queue into the phase output register; one tick per cycle
// while the output is not stalled and no division runs. An update word whose step needs the
// bit-serial divider holds the words behind it in the queue until the quotient is back.
// Reset clears all ramp state to zero and empties the queue at once.
module host_synced_phasor
    import hsp_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  cmd,
    input  logic [FRAC_BITS+16:0] beat_position,
    input  logic                  host_playing,
    input  logic                  host_time_valid,
    output logic                  phase_valid,
    input  logic                  phase_ready,
    output logic [FRAC_BITS+1:0]  phase_out
);

    localparam int WORD_W  = FRAC_BITS + 19;
    localparam int OUT_W   = FRAC_BITS + 2;
    localparam int IdleMag = ((1 << FRAC_BITS) + MARK_ROUND) / MARK_DEN;
    localparam logic signed [OUT_W-1:0] PhaseHi = OUT_W'(1) << FRAC_BITS;
    localparam logic signed [OUT_W-1:0] PhaseLo = OUT_W'(-IdleMag);

    fifo_stat_t            q_stat;
    div_stat_t             div_stat;
    logic                  push;
    logic                  pop;
    logic [WORD_W-1:0]     word_in;
    logic [WORD_W-1:0]     word_out;
    logic                  div_start;
    logic [FRAC_BITS-1:0]  div_dividend;
    logic [COUNT_BITS-1:0] div_divisor;
    logic [FRAC_BITS-1:0]  div_quotient;

    hsp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .cmd             (cmd),
        .beat_position   (beat_position),
        .host_playing    (host_playing),
        .host_time_valid (host_time_valid),
        .q_stat          (q_stat),
        .push            (push),
        .word            (word_in)
    );

    hsp_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (word_in),
        .pop   (pop),
        .rdata (word_out),
        .stat  (q_stat)
    );

    hsp_div #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    hsp_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .word         (word_out),
        .q_stat       (q_stat),
        .pop          (pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quotient (div_quotient),
        .div_stat     (div_stat),
        .phase_valid  (phase_valid),
        .phase_ready  (phase_ready),
        .phase_out    (phase_out)
    );

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_valid |-> ($signed(phase_out) <= PhaseHi && $signed(phase_out) >= PhaseLo))
        else $error("phase word out of range");

    a_hold_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy && phase_valid) |=> $stable(phase_out))
        else $error("phase word changed during step division");

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !div_start)
        else $error("divider restarted while busy");

endmodule

/* hdl/hsp_fifo.sv */
// Short word queue between the front and back parts of the phasor.
// Depends on hsp_pkg for the status struct.
module hsp_fifo
    import hsp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output fifo_stat_t       stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/hsp_front.sv */
// Front part: takes input words, clamps the beat position and tags each word.
// Depends on hsp_pkg.
module hsp_front
    import hsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic                    cmd,
    input  logic [FRAC_BITS+16:0]   beat_position,
    input  logic                    host_playing,
    input  logic                    host_time_valid,
    input  fifo_stat_t              q_stat,
    output logic                    push,
    output logic [FRAC_BITS+18:0]   word
);

    localparam int POS_W = FRAC_BITS + 17;
    localparam logic [POS_W-1:0] PosMax = POS_W'(BEAT_LIMIT) << FRAC_BITS;

    logic [POS_W-1:0] pos_clamped;
    logic             engage;

    assign pos_clamped = (beat_position > PosMax) ? PosMax : beat_position;
    assign engage      = host_playing & host_time_valid;

    assign item_ready = !q_stat.full;
    assign push       = item_valid && !q_stat.full;
    assign word       = {cmd, engage, pos_clamped};

endmodule

/* hdl/hsp_div.sv */
// Restoring divider, one quotient bit per cycle, for the per-sample step.
// Depends on hsp_pkg for the status struct.
module hsp_div
    import hsp_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FRAC_BITS-1:0]  dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic [FRAC_BITS-1:0]  quotient,
    output div_stat_t             stat
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [FRAC_BITS-1:0]  quo_reg;
    logic [COUNT_BITS-1:0] den_reg;
    logic [COUNT_BITS:0]   shifted;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;
    logic [COUNT_BITS-1:0] rem_next;
    logic [FRAC_BITS-1:0]  quo_next;

    assign shifted  = {rem_reg, quo_reg[FRAC_BITS-1]};
    assign diff     = shifted - {1'b0, den_reg};
    assign ge       = (shifted >= {1'b0, den_reg});
    assign rem_next = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    assign quo_next = {quo_reg[FRAC_BITS-2:0], ge};

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/hsp_back.sv */
// Back part: runs host updates and sample ticks, holds the ramp state and
// the output register. Depends on hsp_pkg; drives the hsp_div divider.
module hsp_back
    import hsp_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FRAC_BITS+18:0] word,
    input  fifo_stat_t            q_stat,
    output logic                  pop,
    output logic                  div_start,
    output logic [FRAC_BITS-1:0]  div_dividend,
    output logic [COUNT_BITS-1:0] div_divisor,
    input  logic [FRAC_BITS-1:0]  div_quotient,
    input  div_stat_t             div_stat,
    output logic                  phase_valid,
    input  logic                  phase_ready,
    output logic [FRAC_BITS+1:0]  phase_out
);

    localparam int POS_W  = FRAC_BITS + 17;
    localparam int WORD_W = POS_W + 2;
    localparam int OUT_W  = FRAC_BITS + 2;
    localparam int STEP_W = FRAC_BITS + 1;
    localparam int SUM_W  = FRAC_BITS + 3;
    localparam int IdleMag = ((1 << FRAC_BITS) + MARK_ROUND) / MARK_DEN;
    localparam logic [OUT_W-1:0]        IdlePhase = OUT_W'(-IdleMag);
    localparam logic [STEP_W-1:0]       StepOne   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SUM_W-1:0] SumOne    = {3'b001, {FRAC_BITS{1'b0}}};

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t                  state_reg;
    logic [POS_W-1:0]        last_position_reg;
    logic [FRAC_BITS-1:0]    last_fraction_reg;
    logic [STEP_W-1:0]       phase_step_reg;
    logic signed [OUT_W-1:0] ramp_phase_reg;
    logic [COUNT_BITS-1:0]   samples_reg;
    logic                    phase_valid_reg;
    logic [OUT_W-1:0]        phase_out_reg;

    logic                    is_tick;
    logic                    engage;
    logic [POS_W-1:0]        pos;
    logic [FRAC_BITS-1:0]    frac;
    logic [FRAC_BITS-1:0]    delta;
    logic                    active;
    logic                    can_emit;
    logic                    samples_zero;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] wrapped;
    logic [OUT_W-1:0]        phase_next;

    assign is_tick = (word[WORD_W-1] == CMD_TICK);
    assign engage  = word[POS_W];
    assign pos     = word[POS_W-1:0];
    assign frac    = pos[FRAC_BITS-1:0];
    assign delta   = frac - last_fraction_reg;
    assign active  = (pos != last_position_reg) && engage;

    assign samples_zero = (samples_reg == '0);
    assign can_emit     = !phase_valid_reg || phase_ready;

    assign sum = $signed({{(SUM_W - OUT_W){ramp_phase_reg[OUT_W-1]}}, ramp_phase_reg})
               + $signed({{(SUM_W - STEP_W){1'b0}}, phase_step_reg});
    assign wrapped    = (sum > SumOne) ? sum - SumOne : sum;
    assign phase_next = wrapped[OUT_W-1:0];

    assign pop = (state_reg == ST_IDLE) && !q_stat.empty && (!is_tick || can_emit);
    assign div_start = (state_reg == ST_IDLE) && !q_stat.empty && !is_tick
                     && active && !samples_zero;
    assign div_dividend = delta;
    assign div_divisor  = samples_reg;

    assign phase_valid = phase_valid_reg;
    assign phase_out   = phase_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            last_position_reg <= '0;
            last_fraction_reg <= '0;
            phase_step_reg    <= '0;
            ramp_phase_reg    <= '0;
            samples_reg       <= '0;
            phase_valid_reg   <= 1'b0;
            phase_out_reg     <= '0;
        end
        else
        begin
            if (phase_valid_reg && phase_ready && !(pop && is_tick))
            begin
                phase_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop && is_tick)
                    begin
                        ramp_phase_reg  <= phase_next;
                        phase_out_reg   <= phase_next;
                        phase_valid_reg <= 1'b1;
                        if (!(&samples_reg))
                        begin
                            samples_reg <= samples_reg + 1'b1;
                        end
                    end
                    else if (pop)
                    begin
                        samples_reg <= '0;
                        if (active)
                        begin
                            last_position_reg <= pos;
                            last_fraction_reg <= frac;
                            ramp_phase_reg    <= {2'b00, frac};
                            if (samples_zero)
                            begin
                                phase_step_reg <= (delta != '0) ? StepOne : '0;
                            end
                            else
                            begin
                                state_reg <= ST_DIVIDE;
                            end
                        end
                        else
                        begin
                            ramp_phase_reg    <= IdlePhase;
                            phase_step_reg    <= '0;
                            last_fraction_reg <= '0;
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        phase_step_reg <= {1'b0, div_quotient};
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* test/tb.sv */
// Self-checking bench for host_synced_phasor: a table of directed words, then
// random host updates and sample ticks, checked against a phasor tracker.
// Depends on hsp_pkg and the host_synced_phasor RTL.
`timescale 1ns / 100ps

module tb;
    import hsp_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int PW        = FB + 17;
    localparam int OW        = FB + 2;
    localparam int N_RANDOM  = 1000;
    localparam int STALL_MAX = 3000;
    localparam int HOLD_LEN  = 400;
    localparam logic [PW-1:0] POS_TOP  = PW'(BEAT_LIMIT) << FB;
    localparam logic [PW-1:0] POS_ONES = '1;
    localparam logic [OW-1:0] MARK_OUT = OW'(-(((1 << FB) + MARK_ROUND) / MARK_DEN));

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          item_valid = 1'b0;
    logic          item_ready;
    logic          cmd = CMD_UPDATE;
    logic [PW-1:0] beat_position = '0;
    logic          host_playing = 1'b0;
    logic          host_time_valid = 1'b0;
    logic          phase_valid;
    logic          phase_ready = 1'b0;
    logic [OW-1:0] phase_out;

    host_synced_phasor dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .cmd             (cmd),
        .beat_position   (beat_position),
        .host_playing    (host_playing),
        .host_time_valid (host_time_valid),
        .phase_valid     (phase_valid),
        .phase_ready     (phase_ready),
        .phase_out       (phase_out)
    );

    always #5 clk = ~clk;

    // tracker state
    logic [PW-1:0]        seen_pos;
    logic [FB-1:0]        seen_frac;
    logic [FB:0]          ramp_step;
    logic signed [OW+1:0] ramp_acc;
    logic [31:0]          tick_count;

    logic [OW-1:0] phase_due[$];
    int            fails = 0;
    int            sent = 0;
    bit            calm = 0;
    bit            hold_req = 0;

    typedef struct {
        logic          c;
        logic [PW-1:0] pos;
        logic          pl;
        logic          tv;
        bit            typed;
        logic [OW-1:0] want;
    } row_t;

    localparam int N_ROWS = 26;
    row_t rows[N_ROWS] = '{
        '{CMD_TICK,   '0,             0, 0, 1, '0},
        '{CMD_TICK,   POS_ONES,       1, 1, 1, '0},
        '{CMD_UPDATE, '0,             1, 1, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 1, MARK_OUT},
        '{CMD_UPDATE, POS_ONES,       1, 1, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_UPDATE, POS_TOP,        1, 1, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 1, MARK_OUT},
        '{CMD_UPDATE, 33'h0_0001_8000, 0, 1, 0, '0},
        '{CMD_UPDATE, 33'h0_0001_8000, 1, 1, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_UPDATE, 33'h0_0001_C000, 1, 1, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_UPDATE, 33'h0_0002_C000, 1, 0, 0, '0},
        '{CMD_UPDATE, 33'h0_0002_C000, 1, 1, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_UPDATE, 33'h0_0003_4000, 1, 1, 0, '0},
        '{CMD_UPDATE, 33'h0_0004_4000, 1, 1, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0},
        '{CMD_UPDATE, POS_TOP + 1,    1, 1, 0, '0},
        '{CMD_TICK,   '0,             0, 0, 0, '0}
    };

    task automatic track_phasor(input logic c, input logic [PW-1:0] pos_in, input logic pl,
                                input logic tv, output bit emits, output logic [OW-1:0] ph);
        logic [PW-1:0] pos;
        logic [FB-1:0] frac;
        logic [FB:0]   delta;
        logic [31:0]   quot;
        pos   = pos_in;
        emits = 0;
        ph    = '0;
        if (c == CMD_UPDATE)
        begin
            if (pos > POS_TOP)
                pos = POS_TOP;
            if (pos != seen_pos && tv && pl)
            begin
                frac = pos[FB-1:0];
                seen_pos = pos;
                ramp_acc = $signed({4'b0, frac});
                if (frac >= seen_frac)
                    delta = {1'b0, frac} - {1'b0, seen_frac};
                else
                    delta = {1'b1, frac} - {1'b0, seen_frac};
                if (tick_count == 0)
                    ramp_step = (delta != 0) ? (FB+1)'(1 << FB) : '0;
                else
                begin
                    quot = {15'b0, delta} / tick_count;
                    if (quot > (1 << FB))
                        quot = 1 << FB;
                    ramp_step = quot[FB:0];
                end
                seen_frac = frac;
            end
            else
            begin
                ramp_acc  = $signed({{2{MARK_OUT[OW-1]}}, MARK_OUT});
                ramp_step = '0;
                seen_frac = '0;
            end
            tick_count = '0;
        end
        else
        begin
            ramp_acc = ramp_acc + $signed({3'b0, ramp_step});
            if (ramp_acc > (1 << FB))
                ramp_acc = ramp_acc - (1 << FB);
            ph    = ramp_acc[OW-1:0];
            emits = 1;
            if (tick_count != '1)
                tick_count = tick_count + 1;
        end
    endtask

    task automatic push_word(input logic c, input logic [PW-1:0] pos, input logic pl,
                             input logic tv, input bit typed, input logic [OW-1:0] want);
        int            gap;
        bit            emits;
        logic [OW-1:0] ph;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 19)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid      <= 1'b1;
        cmd             <= c;
        beat_position   <= pos;
        host_playing    <= pl;
        host_time_valid <= tv;
        do @(posedge clk); while (!item_ready);
        track_phasor(c, pos, pl, tv, emits, ph);
        if (emits)
            phase_due.push_back(typed ? want : ph);
        sent++;
    endtask

    function automatic logic [PW-1:0] any_pos();
        return {1'($urandom_range(0, 1)), 32'($urandom)};
    endfunction

    // receive and check phase words
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (phase_valid && phase_ready)
            begin
                if (phase_due.size() == 0)
                begin
                    $display("%0t: unexpected phase word, expected none, actual %0d",
                             $time, $signed(phase_out));
                    fails++;
                end
                else
                begin
                    if (phase_out !== phase_due[0])
                    begin
                        $display("%0t: phase mismatch, expected %0d, actual %0d",
                                 $time, $signed(phase_due[0]), $signed(phase_out));
                        fails++;
                    end
                    void'(phase_due.pop_front());
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                phase_ready <= 1'b0;
            end
            else if (calm)
                phase_ready <= 1'b1;
            else
                phase_ready <= ($urandom_range(0, 99) >= 19);
        end
    end

    // end the run when nothing moves for too long
    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_MAX)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (phase_valid && phase_ready))
                stall = 0;
            else
                stall++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [PW-1:0] cursor;
        logic [PW-1:0] next_pos;
        int            burst;
        int            base;
        seen_pos   = '0;
        seen_frac  = '0;
        ramp_step  = '0;
        ramp_acc   = '0;
        tick_count = '0;
        cursor     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            push_word(rows[i].c, rows[i].pos, rows[i].pl, rows[i].tv, rows[i].typed,
                      rows[i].want);

        base = sent;
        while (sent - base < N_RANDOM)
        begin
            hold_req = (sent - base >= 300);
            calm     = (sent - base >= 600) && (sent - base < 750);
            if ($urandom_range(0, 99) < 75)
            begin
                // step the host position forward (or hold it, or restart it low past the top), then a burst of ticks
                if ($urandom_range(0, 9) == 0)
                    next_pos = cursor;
                else
                    next_pos = cursor + PW'($urandom_range(0, 32'h3FFFF));
                if (next_pos > POS_TOP)
                    next_pos = PW'($urandom_range(0, 32'hFFFFF));
                cursor = next_pos;
                push_word(CMD_UPDATE, cursor, 1'b1, 1'b1, 0, '0);
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 12);
                repeat (burst)
                    push_word(CMD_TICK, any_pos(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 0, '0);
            end
            else if ($urandom_range(0, 1) == 0)
                push_word(CMD_UPDATE, any_pos(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 0, '0);
            else
                push_word(CMD_TICK, any_pos(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 0, '0);
        end
        calm = 0;
        item_valid <= 1'b0;

        while (phase_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hsp_pkg.sv
hdl/hsp_fifo.sv
hdl/hsp_front.sv
hdl/hsp_div.sv
hdl/hsp_back.sv
hdl/host_synced_phasor.sv
test/tb.sv
